// ===== rtl/pbsc_pkg.sv =====
// Package for the pileup base/strand counter: parse modes, character codes,
// widths and the base-slot decode. No dependencies.
package pbsc_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int MAX_INDEL_LEN = 1023;
    localparam int INDEL_W       = $clog2(MAX_INDEL_LEN + 1);
    localparam int OUT_CNT_W     = 16;
    localparam int NUM_CNT       = 10;
    localparam int SLOT_W        = $clog2(NUM_CNT);

    localparam int S_TDATA_W = 32;   // 8 + 8 + 8 + 1 packed, byte padded
    localparam int M_TDATA_W = 168;  // 1 + 10 * 16 packed, byte padded

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_SKIP_ONE = 2'd1,
        MODE_LENGTH   = 2'd2,
        MODE_SKIPPING = 2'd3
    } parse_mode_t;

    localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CH_CARET  = 8'h5E;  // '^'
    localparam logic [7:0] CH_DOT    = 8'h2E;  // '.'
    localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
    localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CH_UPPER_Z = 8'd90; // above this counts as reverse
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'

    localparam logic [2:0] SLOT_A = 3'd0;
    localparam logic [2:0] SLOT_C = 3'd1;
    localparam logic [2:0] SLOT_G = 3'd2;
    localparam logic [2:0] SLOT_T = 3'd3;
    localparam logic [2:0] SLOT_N = 3'd4;

    // A/C/G/T in either case, everything else is N
    function automatic logic [2:0] base_slot(input logic [7:0] c);
        logic [2:0] r;
        unique case (c)
            8'h41, 8'h61: r = SLOT_A;
            8'h43, 8'h63: r = SLOT_C;
            8'h47, 8'h67: r = SLOT_G;
            8'h54, 8'h74: r = SLOT_T;
            default:      r = SLOT_N;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/pileup_base_strand_counter.sv =====
// Pileup base/strand counter top level: character parser, ten saturating
// counters and the result register. Depends on pbsc_pkg.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: symbol, quality_char, reference_base,
//                                    clear_counts
//  m_        out  m_tvalid/m_tready  m_tdata: quality_used, fwd_a..fwd_n, rev_a..rev_n
//  cfg_      in   cfg_wen            cfg_wdata: min_base_quality
//
// One character per cycle while m_ takes results: each accepted transfer
// updates parse mode and indel length, clears the counters on clear_counts,
// bumps at most one counter in the accept cycle; its result shows on m_ on the
// next cycle. s_tready is high while the result slot is empty or being taken,
// so transfers stream back to back and a stall on m_ holds s_ off. Synchronous
// active-low reset clears mode, indel length, counters, threshold and the result valid flag.
module pileup_base_strand_counter
    import pbsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] symbol, [15:8] quality_char, [23:16] reference_base,
    // [24] clear_counts, [31:25] zero
    input  logic [S_TDATA_W-1:0] s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] quality_used, then 16 bits each from bit 1 up: fwd_a, fwd_c, fwd_g,
    // fwd_t, fwd_n, rev_a, rev_c, rev_g, rev_t, rev_n; [167:161] zero
    output logic [M_TDATA_W-1:0] m_tdata,

    input  logic                 cfg_wen,
    input  logic [7:0]           cfg_wdata
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam int                    PROD_W  = INDEL_W + 4;
    localparam logic [PROD_W-1:0]     LEN_MAX = PROD_W'(MAX_INDEL_LEN);

    // state
    parse_mode_t             mode_reg, mode_next;
    logic [INDEL_W-1:0]      rem_reg, rem_next;
    logic [COUNT_BITS-1:0]   cnt_reg  [NUM_CNT];
    logic [COUNT_BITS-1:0]   cnt_next [NUM_CNT];
    logic [7:0]              min_q_reg;
    logic                    m_tvalid_reg;
    logic                    used_reg, used_next;

    // input fields
    logic [7:0] symbol, quality_char, reference_base;
    logic       clear_counts;
    logic       s_accept;

    assign symbol         = s_tdata[7:0];
    assign quality_char   = s_tdata[15:8];
    assign reference_base = s_tdata[23:16];
    assign clear_counts   = s_tdata[24];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // decode
    logic              is_digit;
    logic [PROD_W-1:0] len_acc;
    logic [INDEL_W-1:0] rem_dec;
    logic              run_normal;

    assign is_digit = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
    // length * 10 + digit, as two shifts and adds
    assign len_acc  = (PROD_W'(rem_reg) << 3) + (PROD_W'(rem_reg) << 1)
                    + PROD_W'(symbol[3:0]);
    assign rem_dec  = rem_reg - INDEL_W'(1);

    // next parse mode and indel length
    always_comb begin
        mode_next  = mode_reg;
        rem_next   = rem_reg;
        run_normal = 1'b0;
        unique case (mode_reg)
            MODE_SKIP_ONE: mode_next = MODE_NORMAL;
            MODE_LENGTH: begin
                if (is_digit) begin
                    rem_next = (len_acc > LEN_MAX) ? INDEL_W'(MAX_INDEL_LEN)
                                                   : len_acc[INDEL_W-1:0];
                end else if (rem_reg == '0) begin
                    mode_next  = MODE_NORMAL;
                    run_normal = 1'b1;
                end else begin
                    // this symbol is the first skipped character
                    rem_next  = rem_dec;
                    mode_next = (rem_dec != '0) ? MODE_SKIPPING : MODE_NORMAL;
                end
            end
            MODE_SKIPPING: begin
                if (rem_reg != '0) begin
                    rem_next = rem_dec;
                end
                if (rem_reg == '0 || rem_dec == '0) begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_NORMAL: run_normal = 1'b1;
            default:     mode_next = MODE_NORMAL;
        endcase

        if (run_normal) begin
            if (symbol == CH_CARET) begin
                mode_next = MODE_SKIP_ONE;
            end else if (symbol == CH_PLUS || symbol == CH_MINUS) begin
                mode_next = MODE_LENGTH;
                rem_next  = '0;
            end
        end
    end

    // counter select and quality consumption
    logic              bump_en;
    logic [SLOT_W-1:0] bump_idx;
    logic              rev_strand;
    logic [2:0]        slot;

    always_comb begin
        used_next  = 1'b0;
        rev_strand = 1'b0;
        slot       = SLOT_N;
        if (run_normal) begin
            priority if (symbol == CH_DOLLAR || symbol == CH_STAR ||
                         symbol == CH_CARET  || symbol == CH_PLUS ||
                         symbol == CH_MINUS) begin
                used_next = 1'b0;
            end else if (symbol == CH_DOT || symbol == CH_COMMA) begin
                used_next  = 1'b1;
                rev_strand = (symbol == CH_COMMA);
                slot       = base_slot(reference_base);
            end else begin
                used_next  = 1'b1;
                rev_strand = (symbol > CH_UPPER_Z);
                slot       = base_slot(symbol);
            end
        end
        bump_en  = used_next && (quality_char >= min_q_reg);
        bump_idx = rev_strand ? SLOT_W'(slot) + SLOT_W'(5) : SLOT_W'(slot);
    end

    // clear first, then saturating increment of the selected counter
    always_comb begin
        for (int k = 0; k < NUM_CNT; k++) begin
            cnt_next[k] = clear_counts ? '0 : cnt_reg[k];
            if (bump_en && bump_idx == SLOT_W'(k) && cnt_next[k] != CNT_MAX) begin
                cnt_next[k] = cnt_next[k] + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_NORMAL;
            rem_reg      <= '0;
            min_q_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            used_reg     <= 1'b0;
            for (int k = 0; k < NUM_CNT; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            if (cfg_wen) begin
                min_q_reg <= cfg_wdata;
            end
            if (s_accept) begin
                mode_reg     <= mode_next;
                rem_reg      <= rem_next;
                used_reg     <= used_next;
                m_tvalid_reg <= 1'b1;
                for (int k = 0; k < NUM_CNT; k++) begin
                    cnt_reg[k] <= cnt_next[k];
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // counters change only on an accepted transfer, which also loads the
    // result slot, so the result reads them straight from the registers
    always_comb begin
        m_tdata    = '0;
        m_tdata[0] = used_reg;
        for (int k = 0; k < NUM_CNT; k++) begin
            m_tdata[1 + k*OUT_CNT_W +: OUT_CNT_W] = OUT_CNT_W'(cnt_reg[k]);
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // ---- assertions ----
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted transfer produced no result");

    a_skip_one_lasts_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && mode_reg == MODE_SKIP_ONE) |=> mode_reg != MODE_SKIP_ONE)
        else $error("skip-one mode held over a transfer");

    a_skipping_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_SKIPPING |-> rem_reg != '0)
        else $error("skipping mode with zero remaining length");

    a_len_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= INDEL_W'(MAX_INDEL_LEN))
        else $error("indel length above limit");

    a_used_only_counting: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && used_next) |-> run_normal)
        else $error("quality consumed outside normal handling");

endmodule

// ===== tb/sv/pileup_tally_checker.sv =====
// Scoreboard for the pileup base/strand counter: watches s_, m_ and cfg_, keeps
// its own parser and ten saturating tallies, and compares every result transfer.
// Depends on pbsc_pkg.
module pileup_tally_checker
    import pbsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wen,
    input  logic [7:0]           cfg_wdata,
    input  logic                 run_done,
    output int                   fail_count,
    output int                   pending,
    output int                   checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                                  used;
        logic [NUM_CNT-1:0][OUT_CNT_W-1:0]     cnt;
    } tally_snapshot_t;

    string cnt_label [NUM_CNT] = '{"fwd_a", "fwd_c", "fwd_g", "fwd_t", "fwd_n",
                                   "rev_a", "rev_c", "rev_g", "rev_t", "rev_n"};

    parse_mode_t             mode;
    logic [INDEL_W-1:0]      indel_left;
    logic [COUNT_BITS-1:0]   tally [NUM_CNT];
    logic [7:0]              min_qual;
    tally_snapshot_t         tally_expect_q [$];
    bit                      drain_checked;

    initial begin
        fail_count    = 0;
        pending       = 0;
        checked       = 0;
        drain_checked = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < 40)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic int nucleotide_index(input logic [7:0] c);
        case (c)
            "A", "a": return int'(SLOT_A);
            "C", "c": return int'(SLOT_C);
            "G", "g": return int'(SLOT_G);
            "T", "t": return int'(SLOT_T);
            default:  return int'(SLOT_N);
        endcase
    endfunction

    task automatic bump_tally(input int strand, input logic [7:0] c, input logic [7:0] q);
        int k;
        k = strand * 5 + nucleotide_index(c);
        if (q >= min_qual && tally[k] != {COUNT_BITS{1'b1}})
            tally[k]++;
    endtask

    // normal-mode symbol; returns whether the head quality char was consumed
    task automatic take_normal(input logic [7:0] sym, input logic [7:0] q,
                               input logic [7:0] rb, output logic used);
        used = 1'b0;
        if (sym == CH_DOLLAR || sym == CH_STAR) begin
            used = 1'b0;
        end else if (sym == CH_CARET) begin
            mode = MODE_SKIP_ONE;
        end else if (sym == CH_PLUS || sym == CH_MINUS) begin
            mode       = MODE_LENGTH;
            indel_left = '0;
        end else if (sym == CH_DOT || sym == CH_COMMA) begin
            bump_tally((sym == CH_COMMA) ? 1 : 0, rb, q);
            used = 1'b1;
        end else begin
            bump_tally((sym > CH_UPPER_Z) ? 1 : 0, sym, q);
            used = 1'b1;
        end
    endtask

    task automatic parse_and_tally(input logic [7:0] sym, input logic [7:0] q,
                                   input logic [7:0] rb, input logic clr,
                                   output tally_snapshot_t snap);
        logic used;
        int   nxt;
        used = 1'b0;
        if (clr)
            foreach (tally[i]) tally[i] = '0;
        case (mode)
            MODE_SKIP_ONE: begin
                mode = MODE_NORMAL;
            end
            MODE_LENGTH: begin
                if (sym >= CH_ZERO && sym <= CH_NINE) begin
                    nxt = int'(indel_left) * 10 + int'(sym - CH_ZERO);
                    indel_left = (nxt > MAX_INDEL_LEN) ? INDEL_W'(MAX_INDEL_LEN)
                                                       : INDEL_W'(nxt);
                end else if (indel_left == 0) begin
                    mode = MODE_NORMAL;
                    take_normal(sym, q, rb, used);
                end else begin
                    indel_left--;
                    mode = (indel_left != 0) ? MODE_SKIPPING : MODE_NORMAL;
                end
            end
            MODE_SKIPPING: begin
                if (indel_left != 0)
                    indel_left--;
                if (indel_left == 0)
                    mode = MODE_NORMAL;
            end
            default: begin
                take_normal(sym, q, rb, used);
            end
        endcase
        snap.used = used;
        for (int k = 0; k < NUM_CNT; k++)
            snap.cnt[k] = tally[k][OUT_CNT_W-1:0];
    endtask

    always @(posedge aclk) begin
        tally_snapshot_t want;
        tally_snapshot_t got;
        if (!aresetn) begin
            mode       = MODE_NORMAL;
            indel_left = '0;
            min_qual   = '0;
            foreach (tally[i]) tally[i] = '0;
            tally_expect_q.delete();
        end else begin
            // result first: it belongs to an item accepted on an earlier edge
            if (m_tvalid && m_tready) begin
                checked++;
                if (tally_expect_q.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want     = tally_expect_q.pop_front();
                    // quality_used sits in bit 0, the counters from bit 1 up
                    got.used = m_tdata[0];
                    got.cnt  = m_tdata[NUM_CNT*OUT_CNT_W:1];
                    if (got.used !== want.used)
                        report_mismatch($sformatf("quality_used got %0b want %0b",
                                                  got.used, want.used));
                    for (int k = 0; k < NUM_CNT; k++)
                        if (got.cnt[k] !== want.cnt[k])
                            report_mismatch($sformatf("%s got %0d want %0d",
                                            cnt_label[k], got.cnt[k], want.cnt[k]));
                end
            end
            if (s_tvalid && s_tready) begin
                parse_and_tally(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                                s_tdata[24], want);
                tally_expect_q.push_back(want);
            end
            if (cfg_wen)
                min_qual = cfg_wdata;
            if (run_done && !drain_checked) begin
                drain_checked = 1'b1;
                if (tally_expect_q.size() != 0)
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              tally_expect_q.size()));
            end
        end
        pending = tally_expect_q.size();
    end

endmodule

// ===== tb/sv/pileup_base_strand_counter_tb.sv =====
// Testbench top for pileup_base_strand_counter: clock, reset, stimulus on s_
// and cfg_, back-pressure on m_, and the verdict. Depends on pbsc_pkg, the
// block and pileup_tally_checker.
module pileup_base_strand_counter_tb;
    import pbsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 400;   // long m_ stall so s_ backs up
    localparam int RANDOM_PER_PHASE = 115;  // six threshold phases, ~750 items in all

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wen   = 1'b0;
    logic [7:0]           cfg_wdata = '0;
    logic                 run_done  = 1'b0;

    int fail_count;
    int pending;
    int checked;

    // sender bookkeeping
    int  items_sent        = 0;
    int  burst_left        = 0;
    int  thresholds_set    = 0;
    logic [7:0] cur_min_q  = '0;
    bit  hold_off_pending  = 1'b0;

    pileup_base_strand_counter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    pileup_tally_checker tally_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .run_done   (run_done),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Hard stop, well beyond the run time of about 750 transfers under heavy stall
    // and sender gaps, plus two long hold-offs and threshold drains.
    initial begin
        #(2_000_000);
        $display("FAILURE");
        $finish;
    end

    // m_ back-pressure: segments of always-ready, light and heavy random
    // stalls; a requested hold-off drops tready for HOLD_OFF_CYCLES.
    initial begin : receiver
        int stall_pct;
        int seg_len;
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                stall_pct        = 100;
                seg_len          = HOLD_OFF_CYCLES;
            end else begin
                case ($urandom_range(0, 3))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    default: stall_pct = 70;
                endcase
                seg_len = $urandom_range(4, 80);
            end
            repeat (seg_len) begin
                @(negedge aclk);
                m_tready <= ($urandom_range(1, 100) > stall_pct);
            end
        end
    end

    // One s_ transfer. Entered and left just after a falling edge. tvalid
    // stays high from one item to the next inside a burst; between bursts it
    // drops for a random gap (sometimes none, so long stretches run flat out).
    task automatic send_char(input logic [7:0] sym, input logic [7:0] q,
                             input logic [7:0] rb, input logic clr);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, clr, rb, q, sym};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_text(input string txt, input logic [7:0] q, input logic [7:0] rb);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], q, rb, 1'b0);
    endtask

    // Threshold changes only with the block idle: stop offering, let every
    // outstanding result drain, give the single result register a little slack.
    task automatic set_min_quality(input logic [7:0] val);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        cur_min_q = val;
        thresholds_set++;
    endtask

    // half uniform, half within a few codes of the current threshold
    function automatic logic [7:0] pick_quality();
        int v;
        if ($urandom_range(0, 1))
            return 8'($urandom_range(0, 255));
        v = int'(cur_min_q) + $urandom_range(0, 6) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic logic [7:0] pick_base();
        string bases;
        bases = "ACGTNacgtn.,";
        return bases[$urandom_range(0, bases.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_ref();
        string refs;
        refs = "ACGTNacgt";
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return refs[$urandom_range(0, refs.len() - 1)];
    endfunction

    function automatic logic pick_clear();
        return ($urandom_range(0, 49) == 0);
    endfunction

    // One pileup token. Mostly well formed (bases, read starts with their
    // mapping-quality char, read ends, deletions, indels with a decimal
    // length and that many bases); the rest is a bare indel sign or noise.
    task automatic send_read_token();
        int         kind;
        int         len;
        logic [7:0] rb;
        logic [7:0] sign;
        rb   = pick_ref();
        kind = $urandom_range(0, 99);
        sign = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
        if (kind < 55) begin
            send_char(pick_base(), pick_quality(), rb, pick_clear());
        end else if (kind < 65) begin
            send_char(CH_CARET, pick_quality(), rb, pick_clear());
            send_char(8'($urandom_range(33, 126)), pick_quality(), rb, pick_clear());
            send_char(pick_base(), pick_quality(), rb, pick_clear());
        end else if (kind < 72) begin
            send_char(CH_DOLLAR, pick_quality(), rb, pick_clear());
        end else if (kind < 77) begin
            send_char(CH_STAR, pick_quality(), rb, pick_clear());
        end else if (kind < 90) begin
            len = $urandom_range(1, 15);
            send_char(sign, pick_quality(), rb, pick_clear());
            if (len >= 10)
                send_char(CH_ZERO + 8'(len / 10), pick_quality(), rb, pick_clear());
            send_char(CH_ZERO + 8'(len % 10), pick_quality(), rb, pick_clear());
            repeat (len) send_char(pick_base(), pick_quality(), rb, pick_clear());
        end else if (kind < 94) begin
            // sign with no length: next symbol is parsed as a normal one
            send_char(sign, pick_quality(), rb, pick_clear());
            send_char(pick_base(), pick_quality(), rb, pick_clear());
        end else begin
            send_char(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), pick_clear());
        end
    endtask

    initial begin : stimulus
        int         phase_end;
        int         wait_cycles;
        logic [7:0] phase_q [6];

        // synchronous reset
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed, threshold at its reset value 0 ---
        send_text("ACGTNacgtn", 8'd60, "A");         // every base, both strands
        send_char(CH_DOT,   8'd0,   "C", 1'b0);      // ref base, forward, lowest q
        send_char(CH_COMMA, 8'd255, "T", 1'b0);      // ref base, reverse, highest q
        send_char(CH_COMMA, 8'd50,  "x", 1'b0);      // odd ref base lands in rev N
        send_char(CH_DOLLAR, 8'd50, "A", 1'b0);      // read end: ignored
        send_char(CH_STAR,   8'd50, "A", 1'b0);      // deletion: ignored
        send_char(CH_CARET,  8'd50, "A", 1'b0);      // read start...
        send_char("~",       8'd50, "A", 1'b0);      // ...mapping quality skipped
        send_text("+2ACG", 8'd50, "A");              // two-base insert, then G counts
        send_text("-T", 8'd50, "A");                 // sign with no length
        send_char(8'h00, 8'd50, "A", 1'b0);          // other codes count as N
        send_char(8'hFF, 8'd50, "A", 1'b0);
        send_char("7",   8'd50, "A", 1'b0);
        send_char(8'h0A, 8'd50, "A", 1'b0);
        // clear while in skip-one mode: counters drop, parse mode does not
        send_char(CH_CARET, 8'd50, "A", 1'b0);
        send_char("A",      8'd50, "A", 1'b1);
        send_char("a",      8'd50, "A", 1'b0);

        // quality threshold edges
        set_min_quality(8'd40);
        send_char("A",    8'd39, "A", 1'b0);
        send_char("A",    8'd40, "A", 1'b0);
        send_char(CH_DOT, 8'd39, "G", 1'b0);
        set_min_quality(8'd255);
        send_char("c", 8'd254, "A", 1'b0);
        send_char("c", 8'd255, "A", 1'b0);

        // --- random tokens over several thresholds, extremes included ---
        phase_q = '{8'd0, 8'd255, 8'd33, 8'($urandom_range(1, 254)), 8'd128, 8'd1};
        foreach (phase_q[p]) begin
            set_min_quality(phase_q[p]);
            if (p == 1 || p == 4)
                hold_off_pending = 1'b1;
            phase_end = items_sent + RANDOM_PER_PHASE;
            while (items_sent < phase_end)
                send_read_token();
        end

        // drain, bounded, then let the one-deep pipe settle
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(negedge aclk);
            wait_cycles++;
        end
        repeat (8) @(negedge aclk);
        run_done <= 1'b1;
        repeat (2) @(posedge aclk);

        $display("Run covered %0d transfers, %0d results checked, %0d threshold writes.",
                 items_sent, checked, thresholds_set);
        $display("Included every base on both strands, read marks, indels, clears,");
        $display("quality edges and long m_ hold-offs that back up s_.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pbsc_pkg.sv
rtl/pileup_base_strand_counter.sv
tb/sv/pileup_tally_checker.sv
tb/sv/pileup_base_strand_counter_tb.sv
